// ----- rtl/fra_pkg.sv -----
// Shared constants for the frame rate averager.
package fra_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int FRAME_W        = 16;
    localparam int DROP_W         = 8;
    localparam int FPS_W          = 22;
    localparam int MS_PER_SEC     = 1000;
    localparam int FRAC_BITS      = 8;

    localparam logic [FPS_W-1:0]   FPS_MAX     = 22'd4194303;
    localparam logic [FRAME_W-1:0] LIMIT_RESET = 16'd1000;

endpackage

// ----- rtl/fra_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module fra_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0]  r_rem,  n_rem;
    logic [DVD_W-1:0]  r_quo,  n_quo;
    logic [DVS_W-1:0]  r_dvs,  n_dvs;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DVS_W:0]    trial;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[DVD_W-1]};
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_step = STEP_W'(DVD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DVS_W'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = DVS_W'(trial);
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_step = r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/frame_rate_averager_with_drops.sv -----
// Frame rate averager: ring of frame times, dropped-frame sharing, serial fps divide.
// Each transfer writes its frame time and one zero entry per dropped frame, then scans
//   the ring; a sharing pass splits a high entry with a zero entry and rescans, then the
//   serial divide runs (dividend width 23 at depth 16). A frame time above the limit discards history.
// The input stalls until the result issues.
// Reset is synchronous, active low: clears count, pointer, sequencer and output valid,
//   sets the frame-time limit to 1000; ring contents are not cleared.
module frame_rate_averager_with_drops #(
    parameter int RING_DEPTH = fra_pkg::RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [fra_pkg::FRAME_W-1:0]  i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [fra_pkg::FRAME_W-1:0]  i_frame_time,
    input  logic [fra_pkg::DROP_W-1:0]   i_dropped_frames,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [fra_pkg::FPS_W-1:0]    o_fps_q8
);
    import fra_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = FRAME_W + $clog2(RING_DEPTH);
    localparam int DVD_W = CNT_W + 10 + FRAC_BITS;
    localparam int QX_W  = (DVD_W > FPS_W) ? DVD_W : FPS_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DROP = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_FIXH = 7'b0001000,
        S_FIXZ = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    logic [FRAME_W-1:0] r_mem [RING_DEPTH];
    logic [FRAME_W-1:0] r_rd_data;

    t_state             r_state,  n_state;
    logic [FRAME_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [PTR_W-1:0]   r_ptr,    n_ptr;
    logic [DROP_W-1:0]  r_drops,  n_drops;
    logic [CNT_W-1:0]   r_idx,    n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [PTR_W-1:0]   r_rd_at,  n_rd_at;
    logic [SUM_W-1:0]   r_sum,    n_sum;
    logic               r_has_z,  n_has_z;
    logic               r_has_h,  n_has_h;
    logic [PTR_W-1:0]   r_z_at,   n_z_at;
    logic [PTR_W-1:0]   r_h_at,   n_h_at;
    logic [FRAME_W-1:0] r_high,   n_high;
    logic [FPS_W-1:0]   r_res,    n_res;
    logic               r_out_vld, n_out_vld;
    logic [FPS_W-1:0]   r_fps,    n_fps;

    logic               mem_we;
    logic [PTR_W-1:0]   mem_wa;
    logic [FRAME_W-1:0] mem_wd;
    logic [PTR_W-1:0]   mem_ra;
    logic [FRAME_W-1:0] half;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic               div_done;
    logic [DVD_W-1:0]   div_quo;
    logic [QX_W-1:0]    quo_ext;
    logic               issuing;

    fra_div #(
        .DVD_W (DVD_W),
        .DVS_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign half    = FRAME_W'(({1'b0, r_high} + 17'd1) >> 1);
    assign div_dvd = ({{(DVD_W-CNT_W){1'b0}}, r_count} * DVD_W'(MS_PER_SEC)) << FRAC_BITS;
    assign quo_ext = QX_W'(div_quo);
    assign issuing = (r_idx != r_count);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_fps_q8 = r_fps;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_drops   = r_drops;
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_rd_at   = r_rd_at;
        n_sum     = r_sum;
        n_has_z   = r_has_z;
        n_has_h   = r_has_h;
        n_z_at    = r_z_at;
        n_h_at    = r_h_at;
        n_high    = r_high;
        n_res     = r_res;
        n_out_vld = r_out_vld;
        n_fps     = r_fps;
        mem_we    = 1'b0;
        mem_wa    = r_ptr;
        mem_wd    = '0;
        mem_ra    = r_idx[PTR_W-1:0];
        div_start = 1'b0;

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_frame_time > r_limit) begin
                        n_count = '0;
                        n_ptr   = '0;
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        mem_we  = 1'b1;
                        mem_wd  = i_frame_time;
                        n_ptr   = (r_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                        if (r_count != CNT_W'(RING_DEPTH)) begin
                            n_count = r_count + 1'b1;
                        end
                        n_drops = i_dropped_frames;
                        n_state = (i_dropped_frames != '0) ? S_DROP : S_SCAN;
                        n_idx   = '0;
                        n_sum   = '0;
                        n_has_z = 1'b0;
                        n_has_h = 1'b0;
                        n_high  = '0;
                    end
                end
            end
            S_DROP: begin
                mem_we  = 1'b1;
                n_ptr   = (r_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                if (r_count != CNT_W'(RING_DEPTH)) begin
                    n_count = r_count + 1'b1;
                end
                n_drops = r_drops - 1'b1;
                if (r_drops == DROP_W'(1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_at  = r_idx[PTR_W-1:0];
                end
                if (r_rd_vld) begin
                    n_sum = r_sum + SUM_W'(r_rd_data);
                    if (r_rd_data == '0) begin
                        n_has_z = 1'b1;
                        n_z_at  = r_rd_at;
                    end
                    if ({1'b0, r_rd_data} > ({1'b0, r_high} + 17'd1)) begin
                        n_has_h = 1'b1;
                        n_h_at  = r_rd_at;
                        n_high  = r_rd_data;
                    end
                end
                if (!issuing && !r_rd_vld) begin
                    if (r_has_z && r_has_h) begin
                        n_state = S_FIXH;
                    end else if (r_sum == '0) begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_FIXH: begin
                mem_we  = 1'b1;
                mem_wa  = r_h_at;
                mem_wd  = half;
                n_state = S_FIXZ;
            end
            S_FIXZ: begin
                mem_we  = 1'b1;
                mem_wa  = r_z_at;
                mem_wd  = half;
                n_idx   = '0;
                n_sum   = '0;
                n_has_z = 1'b0;
                n_has_h = 1'b0;
                n_high  = '0;
                n_state = S_SCAN;
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = (quo_ext > QX_W'(FPS_MAX)) ? FPS_MAX : FPS_W'(quo_ext);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld = 1'b1;
                    n_fps     = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= LIMIT_RESET;
            r_count   <= '0;
            r_ptr     <= '0;
            r_drops   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_drops   <= n_drops;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_rd_at <= n_rd_at;
        r_sum   <= n_sum;
        r_has_z <= n_has_z;
        r_has_h <= n_has_h;
        r_z_at  <= n_z_at;
        r_h_at  <= n_h_at;
        r_high  <= n_high;
        r_res   <= n_res;
        r_fps   <= n_fps;
    end

endmodule
